/* rtl/tfdcp_pkg.sv */
// Shared constants and types for the two-field decimal command parser.
package tfdcp_pkg;

    localparam int FIELD_CHARS_DEF = 8;
    localparam int CNT_W           = 4;
    localparam int VAL_W           = 16;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic take;
        logic restart;
    } conv_ctrl_t;

endpackage

/* rtl/tfdcp_conv.sv */
// Per-field decimal conversion: whitespace skip, sign, digit accumulation.
module tfdcp_conv #(
    parameter int FIELD_CHARS = tfdcp_pkg::FIELD_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tfdcp_pkg::conv_ctrl_t        ctrl,
    input  logic [tfdcp_pkg::BYTE_W-1:0] char_in,
    output logic [tfdcp_pkg::VAL_W-1:0]  field_val
);
    import tfdcp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FIELD_CHARS);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic               is_digit;
    logic [VAL_W-1:0]   digit_val;
    logic [VAL_W-1:0]   acc_times_ten;

    assign is_digit      = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign digit_val     = VAL_W'(char_in - CHAR_ZERO);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);
    assign field_val     = neg_reg ? (VAL_W'(0) - acc_reg) : acc_reg;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (ctrl.restart) begin
            phase_next = PH_SKIP;
            cnt_next   = '0;
            neg_next   = 1'b0;
            acc_next   = '0;
        end else if (ctrl.take && (cnt_reg < CNT_MAX)) begin
            cnt_next = cnt_reg + 1'b1;
            case (phase_reg)
                PH_SKIP: begin
                    if (char_in inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]}) begin
                        phase_next = PH_SKIP;
                    end else if (char_in inside {CHAR_PLUS, CHAR_MINUS}) begin
                        neg_next   = (char_in == CHAR_MINUS);
                        phase_next = PH_SIGN;
                    end else if (is_digit) begin
                        acc_next   = digit_val;
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit) begin
                        acc_next   = acc_times_ten + digit_val;
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // Characters beyond the field limit are dropped, so the count saturates there.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("field character count exceeded its limit");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(ctrl.restart) |-> (phase_reg == PH_SKIP) && (acc_reg == '0) && !neg_reg)
        else $error("field state not cleared after a separator");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(phase_reg == PH_DONE) && !$past(ctrl.restart)) |->
            (phase_reg == PH_DONE) && $stable(acc_reg))
        else $error("finished conversion changed without a separator");

endmodule

/* rtl/two_field_decimal_command_parser.sv */
// Top level: byte stream in, pair of 16-bit duty values out on each '!' item.
// Flow: an accepted byte is registered in in_byte_reg and processed from there; a '!'
// item sets the out_valid_reg register, which drives m_tvalid, when it is processed.
// Throughput: one byte item per cycle, limited only by back-pressure on the result
// register when a '!' arrives while a previous result is still waiting.
// Reset: aresetn is synchronous and active low; it clears both values, the field
// state and all valid flags.
module two_field_decimal_command_parser #(
    parameter int FIELD_CHARS = tfdcp_pkg::FIELD_CHARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tfdcp_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*tfdcp_pkg::VAL_W-1:0] m_tdata    // [15:0] duty_a, [31:16] duty_b
);
    import tfdcp_pkg::*;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 out_valid_reg;
    logic [2*VAL_W-1:0]   out_data_reg;
    logic                 second_reg;
    logic [VAL_W-1:0]     first_val_reg, first_val_next;
    logic [VAL_W-1:0]     second_val_reg, second_val_next;
    logic                 proc;
    logic                 is_dot, is_bang;
    conv_ctrl_t           conv_ctrl;
    logic [VAL_W-1:0]     field_val;

    assign is_dot  = (in_byte_reg == CHAR_DOT);
    assign is_bang = (in_byte_reg == CHAR_BANG);

    // A held byte goes through unless it is a '!' facing a stalled result.
    assign proc     = in_valid_reg && !(is_bang && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign conv_ctrl.restart = proc && (is_dot || is_bang);
    assign conv_ctrl.take    = proc && !is_dot && !is_bang;

    tfdcp_conv #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (conv_ctrl),
        .char_in   (in_byte_reg),
        .field_val (field_val)
    );

    always_comb begin
        first_val_next  = first_val_reg;
        second_val_next = second_val_reg;
        if (second_reg) begin
            second_val_next = field_val;
        end else begin
            first_val_next = field_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            second_reg     <= 1'b0;
            first_val_reg  <= '0;
            second_val_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc && is_bang) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (conv_ctrl.restart) begin
                first_val_reg  <= first_val_next;
                second_val_reg <= second_val_next;
                second_reg     <= is_dot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (proc && is_bang) begin
            out_data_reg <= {second_val_next, first_val_next};
        end
    end

    a_result_from_bang: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(proc && is_bang))
        else $error("result raised without a frame end");

    a_bang_resets_field: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(proc && is_bang) |-> !second_reg && out_valid_reg)
        else $error("frame end did not return to the first field");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid_reg && is_bang) |-> !proc)
        else $error("waiting result overwritten");

endmodule
